// ===== rtl/mme_pkg.sv =====
// Shared types and constants for the matrix multiply engine.
`default_nettype none
package mme_pkg;

   localparam int MAX_DIM = 8;

   localparam int CFG_W   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int FUNC_W  = 2;
   localparam int POS_W   = 3;
   localparam int ELEM_W  = 16;
   localparam int PROD_W  = 2 * ELEM_W;
   localparam int SUM_W   = 35;

   localparam logic [FUNC_W-1:0] FUNC_WRITE_A = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE_B = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_A_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_A_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B_ROWS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_B_COLS = 2'd3;

   localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_OUTPUT
   } mme_state_type;

   // zero reads as one, anything above the store size reads as the store size
   function automatic logic [CFG_W-1:0] dim_clamp(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W:0] lim);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if ({1'b0, v} > lim) begin
         r = lim[CFG_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/matrix_multiply_engine_unit.sv =====
// Matrix multiply engine: A and B stores, one shared multiply-accumulate under a sequencer.
// Element writes: one beat per cycle, no result. Mismatch error: its result the next cycle.
// Compute: each result takes one MAC step per inner index, then the store read register,
// the product register and the accumulator, plus the wait for rsp_ready.
// Not ready while a compute command runs.
// Reset clears the sequencer and sets all dimension registers to 8; stores are not cleared.
`default_nettype none
module matrix_multiply_engine_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [mme_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [mme_pkg::POS_W-1:0]        req_row_index,
   input  wire logic [mme_pkg::POS_W-1:0]        req_col_index,
   input  wire logic signed [mme_pkg::ELEM_W-1:0] req_element_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [mme_pkg::POS_W-1:0]             rsp_out_row,
   output logic [mme_pkg::POS_W-1:0]             rsp_out_col,
   output logic signed [mme_pkg::SUM_W-1:0]      rsp_product_value,
   output logic                                  rsp_dim_error,
   output logic                                  rsp_last_result,
   input  wire logic                             csr_write_en,
   input  wire logic [mme_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mme_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int MAX_DIM = mme_pkg::MAX_DIM;
   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [mme_pkg::CFG_W:0] DIM_LIM = (mme_pkg::CFG_W + 1)'(MAX_DIM);

   mme_pkg::mme_state_type state_ff, state_in;

   logic [mme_pkg::CFG_W-1:0] a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   logic [mme_pkg::CFG_W-1:0] ar, ac, br, bc;

   logic [mme_pkg::CFG_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic                      err_ff, err_in;

   // MAC pipeline: read -> product -> accumulate
   logic                             v1_ff, first1_ff, last1_ff;
   logic                             v2_ff, first2_ff, last2_ff;
   logic signed [mme_pkg::PROD_W-1:0] prod_ff;
   logic signed [mme_pkg::SUM_W-1:0]  acc_ff;

   logic [ADDR_W-1:0]                 wr_addr, rd_addr_a, rd_addr_b;
   logic                              wr_in_range, wr_a, wr_b;
   logic [mme_pkg::ELEM_W-1:0]        a_rd, b_rd;
   logic                              issue, k_last, pos_last, req_fire;

   assign ar = mme_pkg::dim_clamp(a_rows_ff, DIM_LIM);
   assign ac = mme_pkg::dim_clamp(a_cols_ff, DIM_LIM);
   assign br = mme_pkg::dim_clamp(b_rows_ff, DIM_LIM);
   assign bc = mme_pkg::dim_clamp(b_cols_ff, DIM_LIM);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= mme_pkg::DIM_RESET;
         a_cols_ff <= mme_pkg::DIM_RESET;
         b_rows_ff <= mme_pkg::DIM_RESET;
         b_cols_ff <= mme_pkg::DIM_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            mme_pkg::REG_A_ROWS: a_rows_ff <= csr_wdata;
            mme_pkg::REG_A_COLS: a_cols_ff <= csr_wdata;
            mme_pkg::REG_B_ROWS: b_rows_ff <= csr_wdata;
            mme_pkg::REG_B_COLS: b_cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // element writes
   assign req_fire    = req_valid && req_ready;
   assign wr_in_range = (32'(req_row_index) < MAX_DIM) && (32'(req_col_index) < MAX_DIM);
   assign wr_a = req_fire && wr_in_range && (req_func == mme_pkg::FUNC_WRITE_A);
   assign wr_b = req_fire && wr_in_range && (req_func == mme_pkg::FUNC_WRITE_B);
   assign wr_addr = ADDR_W'(ADDR_W'(req_row_index) * ADDR_W'(MAX_DIM))
                  + ADDR_W'(req_col_index);

   assign rd_addr_a = ADDR_W'(ADDR_W'(i_ff[IDX_W-1:0]) * ADDR_W'(MAX_DIM))
                    + ADDR_W'(k_ff[IDX_W-1:0]);
   assign rd_addr_b = ADDR_W'(ADDR_W'(k_ff[IDX_W-1:0]) * ADDR_W'(MAX_DIM))
                    + ADDR_W'(j_ff[IDX_W-1:0]);

   mme_ram #(.WIDTH(mme_pkg::ELEM_W), .DEPTH(DEPTH)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (req_element_value),
      .rd_addr (rd_addr_a),
      .rd_data (a_rd)
   );

   mme_ram #(.WIDTH(mme_pkg::ELEM_W), .DEPTH(DEPTH)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (req_element_value),
      .rd_addr (rd_addr_b),
      .rd_data (b_rd)
   );

   assign issue    = (state_ff == mme_pkg::ST_ISSUE);
   assign k_last   = (k_ff == ac - mme_pkg::CFG_W'(1));
   assign pos_last = (i_ff == ar - mme_pkg::CFG_W'(1)) && (j_ff == bc - mme_pkg::CFG_W'(1));

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      err_in    = err_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         mme_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_func == mme_pkg::FUNC_COMPUTE) begin
               i_in   = '0;
               j_in   = '0;
               k_in   = '0;
               err_in = (ac != br);
               state_in = (ac != br) ? mme_pkg::ST_OUTPUT : mme_pkg::ST_ISSUE;
            end
         end
         mme_pkg::ST_ISSUE: begin
            if (k_last) begin
               state_in = mme_pkg::ST_DRAIN;
            end else begin
               k_in = k_ff + mme_pkg::CFG_W'(1);
            end
         end
         mme_pkg::ST_DRAIN: begin
            // accumulator takes the final product at this edge
            if (v2_ff && last2_ff) begin
               state_in = mme_pkg::ST_OUTPUT;
            end
         end
         mme_pkg::ST_OUTPUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               k_in = '0;
               if (err_ff || pos_last) begin
                  state_in = mme_pkg::ST_IDLE;
               end else begin
                  state_in = mme_pkg::ST_ISSUE;
                  if (j_ff == bc - mme_pkg::CFG_W'(1)) begin
                     j_in = '0;
                     i_in = i_ff + mme_pkg::CFG_W'(1);
                  end else begin
                     j_in = j_ff + mme_pkg::CFG_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = mme_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mme_pkg::ST_IDLE;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         err_ff   <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
         err_ff   <= err_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      first1_ff <= (k_ff == '0);
      last1_ff  <= k_last;
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      prod_ff   <= $signed(a_rd) * $signed(b_rd);
      if (v2_ff) begin
         if (first2_ff) begin
            acc_ff <= mme_pkg::SUM_W'(prod_ff);
         end else begin
            acc_ff <= acc_ff + mme_pkg::SUM_W'(prod_ff);
         end
      end
   end

   assign rsp_out_row       = mme_pkg::POS_W'(i_ff);
   assign rsp_out_col       = mme_pkg::POS_W'(j_ff);
   assign rsp_product_value = err_ff ? '0 : acc_ff;
   assign rsp_dim_error     = err_ff;
   assign rsp_last_result   = err_ff || pos_last;

endmodule
`default_nettype wire

// ===== rtl/mme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== tb/mme_checker.sv =====
// Result checker for the matrix multiply engine: mirrors stores and sizes, predicts beats.
module mme_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic [mme_pkg::FUNC_W-1:0]        req_func,
   input  wire logic [mme_pkg::POS_W-1:0]         req_row_index,
   input  wire logic [mme_pkg::POS_W-1:0]         req_col_index,
   input  wire logic signed [mme_pkg::ELEM_W-1:0] req_element_value,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [mme_pkg::POS_W-1:0]         rsp_out_row,
   input  wire logic [mme_pkg::POS_W-1:0]         rsp_out_col,
   input  wire logic signed [mme_pkg::SUM_W-1:0]  rsp_product_value,
   input  wire logic                              rsp_dim_error,
   input  wire logic                              rsp_last_result,
   input  wire logic                              csr_write_en,
   input  wire logic [mme_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mme_pkg::CFG_W-1:0]         csr_wdata,
   output int                                     fail_count,
   output int                                     pending_results
);

   localparam int STORE_DIM = mme_pkg::MAX_DIM;

   typedef struct packed {
      logic [mme_pkg::POS_W-1:0]        row;
      logic [mme_pkg::POS_W-1:0]        col;
      logic signed [mme_pkg::SUM_W-1:0] value;
      logic                             dim_error;
      logic                             last;
   } product_beat_type;

   product_beat_type expected_products[$];

   logic signed [mme_pkg::ELEM_W-1:0] a_store [STORE_DIM*STORE_DIM];
   logic signed [mme_pkg::ELEM_W-1:0] b_store [STORE_DIM*STORE_DIM];
   logic [mme_pkg::CFG_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;

   function automatic int effective_dim(input logic [mme_pkg::CFG_W-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > STORE_DIM) begin
         return STORE_DIM;
      end
      return int'(v);
   endfunction

   // queue every beat one compute command should produce
   task automatic predict_products();
      int ar, ac, br, bc;
      longint acc;
      product_beat_type beat;
      ar = effective_dim(a_rows_reg);
      ac = effective_dim(a_cols_reg);
      br = effective_dim(b_rows_reg);
      bc = effective_dim(b_cols_reg);
      if (ac != br) begin
         beat = '0;
         beat.dim_error = 1'b1;
         beat.last = 1'b1;
         expected_products.push_back(beat);
      end else begin
         for (int i = 0; i < ar; i++) begin
            for (int j = 0; j < bc; j++) begin
               acc = 0;
               for (int k = 0; k < ac; k++) begin
                  acc += longint'(a_store[i*STORE_DIM+k]) *
                         longint'(b_store[k*STORE_DIM+j]);
               end
               beat = '0;
               beat.row = mme_pkg::POS_W'(i);
               beat.col = mme_pkg::POS_W'(j);
               beat.value = acc[mme_pkg::SUM_W-1:0];
               beat.last = (i == ar - 1) && (j == bc - 1);
               expected_products.push_back(beat);
            end
         end
      end
   endtask

   always @(posedge clock) begin : watch
      product_beat_type want;
      product_beat_type got;
      if (reset) begin
         a_rows_reg = mme_pkg::DIM_RESET;
         a_cols_reg = mme_pkg::DIM_RESET;
         b_rows_reg = mme_pkg::DIM_RESET;
         b_cols_reg = mme_pkg::DIM_RESET;
         expected_products.delete();
         fail_count = 0;
      end else begin
         // result side first: a beat leaving now belongs to an earlier command
         if (rsp_valid && rsp_ready) begin
            got.row = rsp_out_row;
            got.col = rsp_out_col;
            got.value = rsp_product_value;
            got.dim_error = rsp_dim_error;
            got.last = rsp_last_result;
            if (expected_products.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: unexpected result beat row %0d col %0d value %0d err %b last %b",
                           $time, got.row, got.col, got.value, got.dim_error, got.last);
               end
            end else begin
               want = expected_products.pop_front();
               if (got.row !== want.row || got.col !== want.col ||
                   got.value !== want.value || got.dim_error !== want.dim_error ||
                   got.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: result mismatch, expected row %0d col %0d value %0d %s",
                              $time, want.row, want.col, want.value,
                              $sformatf("err %b last %b", want.dim_error, want.last));
                     $display("%0t:                  got row %0d col %0d value %0d %s",
                              $time, got.row, got.col, got.value,
                              $sformatf("err %b last %b", got.dim_error, got.last));
                  end
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               mme_pkg::REG_A_ROWS: a_rows_reg = csr_wdata;
               mme_pkg::REG_A_COLS: a_cols_reg = csr_wdata;
               mme_pkg::REG_B_ROWS: b_rows_reg = csr_wdata;
               mme_pkg::REG_B_COLS: b_cols_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_func)
               mme_pkg::FUNC_WRITE_A: begin
                  a_store[int'(req_row_index)*STORE_DIM + int'(req_col_index)] =
                     req_element_value;
               end
               mme_pkg::FUNC_WRITE_B: begin
                  b_store[int'(req_row_index)*STORE_DIM + int'(req_col_index)] =
                     req_element_value;
               end
               mme_pkg::FUNC_COMPUTE: begin
                  predict_products();
               end
               default: ;
            endcase
         end
      end
      pending_results <= expected_products.size();
   end

endmodule

// ===== tb/matrix_multiply_engine_unit_tb.sv =====
// Testbench top for the matrix multiply engine: stimulus, handshake pacing and the verdict.
module matrix_multiply_engine_unit_tb;

   localparam logic [mme_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int STORE_DIM = mme_pkg::MAX_DIM;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [mme_pkg::FUNC_W-1:0] req_func = '0;
   logic [mme_pkg::POS_W-1:0] req_row_index = '0;
   logic [mme_pkg::POS_W-1:0] req_col_index = '0;
   logic signed [mme_pkg::ELEM_W-1:0] req_element_value = '0;
   logic rsp_ready = 1'b0;
   logic csr_write_en = 1'b0;
   logic [mme_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mme_pkg::CFG_W-1:0] csr_wdata = '0;

   logic req_ready;
   logic rsp_valid;
   logic [mme_pkg::POS_W-1:0] rsp_out_row;
   logic [mme_pkg::POS_W-1:0] rsp_out_col;
   logic signed [mme_pkg::SUM_W-1:0] rsp_product_value;
   logic rsp_dim_error;
   logic rsp_last_result;

   int fail_count;
   int pending_results;

   int burst_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int stall_timer = 0;
   bit a_loaded [STORE_DIM*STORE_DIM];
   bit b_loaded [STORE_DIM*STORE_DIM];
   int use_ar = 8, use_ac = 8, use_br = 8, use_bc = 8;
   int sent_items = 0;

   matrix_multiply_engine_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_dim_error     (rsp_dim_error),
      .rsp_last_result   (rsp_last_result),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   mme_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_dim_error     (rsp_dim_error),
      .rsp_last_result   (rsp_last_result),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending_results   (pending_results)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #100000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side stalls in randomly chosen modes, each held until the stall timer runs out
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_timer = $urandom_range(8, 80);
      end
      stall_timer--;
      case (stall_mode)
         STALL_NONE:  rsp_ready <= 1'b1;
         STALL_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
         STALL_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_ready <= ((stall_timer % 7) < 2);
      endcase
   end

   function automatic int used_dim(input logic [mme_pkg::CFG_W-1:0] v);
      return (v == '0) ? 1 : (int'(v) > STORE_DIM) ? STORE_DIM : int'(v);
   endfunction

   function automatic logic [mme_pkg::CFG_W-1:0] corner_dim();
      case ($urandom_range(0, 3))
         0: return 4'd0;
         1: return 4'd15;
         2: return 4'd1;
         default: return 4'd8;
      endcase
   endfunction

   function automatic logic signed [mme_pkg::ELEM_W-1:0] rand_elem();
      case ($urandom_range(0, 15))
         0, 1: return 16'sh8000;
         2, 3: return 16'sh7fff;
         4: return 16'sh0000;
         default: return mme_pkg::ELEM_W'($urandom);
      endcase
   endfunction

   // one request beat, paced in bursts with idle gaps between them
   task automatic send_item(input logic [mme_pkg::FUNC_W-1:0] func,
                            input logic [mme_pkg::POS_W-1:0] row,
                            input logic [mme_pkg::POS_W-1:0] col,
                            input logic signed [mme_pkg::ELEM_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func <= func;
      req_row_index <= row;
      req_col_index <= col;
      req_element_value <= value;
      do @(posedge clock); while (!req_ready);
      sent_items++;
      if (func == mme_pkg::FUNC_WRITE_A) begin
         a_loaded[int'(row)*STORE_DIM + int'(col)] = 1'b1;
      end else if (func == mme_pkg::FUNC_WRITE_B) begin
         b_loaded[int'(row)*STORE_DIM + int'(col)] = 1'b1;
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      // let any write still in flight settle before touching registers
      repeat (12) @(posedge clock);
   endtask

   task automatic set_dims(input logic [mme_pkg::CFG_W-1:0] ar,
                           input logic [mme_pkg::CFG_W-1:0] ac,
                           input logic [mme_pkg::CFG_W-1:0] br,
                           input logic [mme_pkg::CFG_W-1:0] bc);
      csr_write_en <= 1'b1;
      csr_index <= mme_pkg::REG_A_ROWS;
      csr_wdata <= ar;
      @(posedge clock);
      csr_index <= mme_pkg::REG_A_COLS;
      csr_wdata <= ac;
      @(posedge clock);
      csr_index <= mme_pkg::REG_B_ROWS;
      csr_wdata <= br;
      @(posedge clock);
      csr_index <= mme_pkg::REG_B_COLS;
      csr_wdata <= bc;
      @(posedge clock);
      csr_write_en <= 1'b0;
      use_ar = used_dim(ar);
      use_ac = used_dim(ac);
      use_br = used_dim(br);
      use_bc = used_dim(bc);
   endtask

   initial begin : stimulus
      int sel, phase_len, op, cmp_max, lim_r, lim_c;
      logic [mme_pkg::CFG_W-1:0] ar, ac, br, bc;
      logic [mme_pkg::POS_W-1:0] row, col;
      logic [mme_pkg::FUNC_W-1:0] wfunc;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // full-depth row times column: most negative elements give the largest sum
      set_dims(4'd1, 4'd8, 4'd8, 4'd1);
      for (int k = 0; k < STORE_DIM; k++) begin
         send_item(mme_pkg::FUNC_WRITE_A, 3'd0, 3'(k), 16'sh8000);
      end
      for (int k = 0; k < STORE_DIM; k++) begin
         send_item(mme_pkg::FUNC_WRITE_B, 3'(k), 3'd0, 16'sh8000);
      end
      send_item(mme_pkg::FUNC_COMPUTE, 3'd7, 3'd7, 16'sh7fff);
      // most negative sum
      for (int k = 0; k < STORE_DIM; k++) begin
         send_item(mme_pkg::FUNC_WRITE_B, 3'(k), 3'd0, 16'sh7fff);
      end
      send_item(mme_pkg::FUNC_COMPUTE, 3'd0, 3'd0, 16'sh0000);
      send_item(FUNC_UNUSED, 3'd7, 3'd7, 16'sh8000);
      wait_idle();
      // zero reads as one and fifteen as eight
      set_dims(4'd0, 4'd15, 4'd8, 4'd0);
      send_item(mme_pkg::FUNC_COMPUTE, 3'd5, 3'd2, 16'sh1234);
      wait_idle();
      // inner dimensions disagree
      set_dims(4'd2, 4'd3, 4'd5, 4'd2);
      send_item(mme_pkg::FUNC_COMPUTE, 3'd1, 3'd6, 16'sh5555);
      send_item(mme_pkg::FUNC_COMPUTE, 3'd6, 3'd1, 16'shaaaa);

      while (sent_items < 170) begin
         wait_idle();
         sel = $urandom_range(0, 9);
         case (sel)
            0: begin
               ar = $urandom_range(0, 1) ? 4'd8 : 4'd15;
               ac = $urandom_range(0, 1) ? 4'd8 : 4'd15;
               br = $urandom_range(0, 1) ? 4'd8 : 4'd15;
               bc = $urandom_range(0, 1) ? 4'd8 : 4'd15;
            end
            1: begin
               ar = mme_pkg::CFG_W'($urandom);
               bc = mme_pkg::CFG_W'($urandom);
               do begin
                  ac = mme_pkg::CFG_W'($urandom);
                  br = mme_pkg::CFG_W'($urandom);
               end while (used_dim(ac) == used_dim(br));
            end
            2: begin
               ar = corner_dim();
               ac = corner_dim();
               br = corner_dim();
               bc = corner_dim();
            end
            default: begin
               ar = mme_pkg::CFG_W'($urandom_range(1, 4));
               ac = mme_pkg::CFG_W'($urandom_range(1, 4));
               br = ac;
               bc = mme_pkg::CFG_W'($urandom_range(1, 4));
            end
         endcase
         set_dims(ar, ac, br, bc);

         // every entry a compute will read gets written first
         if (use_ac == use_br) begin
            for (int r = 0; r < use_ar; r++) begin
               for (int k = 0; k < use_ac; k++) begin
                  if (!a_loaded[r*STORE_DIM + k]) begin
                     send_item(mme_pkg::FUNC_WRITE_A, 3'(r), 3'(k), rand_elem());
                  end
               end
            end
            for (int k = 0; k < use_br; k++) begin
               for (int c = 0; c < use_bc; c++) begin
                  if (!b_loaded[k*STORE_DIM + c]) begin
                     send_item(mme_pkg::FUNC_WRITE_B, 3'(k), 3'(c), rand_elem());
                  end
               end
            end
         end

         phase_len = $urandom_range(15, 35);
         cmp_max = (use_ar * use_bc > 16) ? 1 : 5;
         repeat (phase_len) begin
            op = $urandom_range(0, 19);
            if (op == 0) begin
               send_item(FUNC_UNUSED, mme_pkg::POS_W'($urandom), mme_pkg::POS_W'($urandom),
                         mme_pkg::ELEM_W'($urandom));
            end else if (op <= cmp_max) begin
               send_item(mme_pkg::FUNC_COMPUTE, mme_pkg::POS_W'($urandom),
                         mme_pkg::POS_W'($urandom), mme_pkg::ELEM_W'($urandom));
            end else begin
               wfunc = (op % 2 != 0) ? mme_pkg::FUNC_WRITE_A : mme_pkg::FUNC_WRITE_B;
               lim_r = (wfunc == mme_pkg::FUNC_WRITE_A) ? use_ar : use_br;
               lim_c = (wfunc == mme_pkg::FUNC_WRITE_A) ? use_ac : use_bc;
               if ($urandom_range(0, 3) != 0) begin
                  row = mme_pkg::POS_W'($urandom_range(0, lim_r - 1));
                  col = mme_pkg::POS_W'($urandom_range(0, lim_c - 1));
               end else begin
                  row = mme_pkg::POS_W'($urandom);
                  col = mme_pkg::POS_W'($urandom);
               end
               send_item(wfunc, row, col, rand_elem());
            end
         end
      end

      wait_idle();
      repeat (30) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
